### rtl/core/kmrd_pkg.sv
// shared constants, types and helpers for the key matrix row debouncer
package kmrd_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 12;

  localparam int NOW_W       = 16;
  localparam int COL_W       = 12;
  localparam int LEN_W       = 4;
  localparam int ROW_OUT_W   = 2;
  localparam int TOTAL_OUT_W = 6;
  localparam int HIST_W      = 8;
  localparam int SHIFT_W     = 4;

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W   = $clog2(COLS + 1);
  localparam int TOTAL_W = $clog2(ROWS * COLS + 1);
  localparam int TOTAL_SAT = (1 << TOTAL_OUT_W) - 1;

  localparam logic [LEN_W-1:0]   LEN_RST    = LEN_W'(5);
  localparam logic [LEN_W-1:0]   LEN_MIN    = LEN_W'(1);
  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(HIST_W);
  localparam logic [SHIFT_W-1:0] SHIFT_FULL = SHIFT_W'(HIST_W);

  typedef logic [NOW_W-1:0]       now_t;
  typedef logic [COL_W-1:0]       col_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [COLS-1:0]        keys_t;
  typedef logic [HIST_W-1:0]      hist_t;
  typedef logic [COLS*HIST_W-1:0] hist_row_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  // item in flight between the memory read and the output register
  typedef struct packed {
    row_t                row;
    logic                sampled;
    logic [SHIFT_W-1:0]  shift;
    col_t                cols;
  } scan_t;

  function automatic logic [CNT_W-1:0] pop_keys(input keys_t k);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < COLS; i++) begin
      n = n + CNT_W'(k[i]);
    end
    return n;
  endfunction

endpackage

### rtl/core/kmrd_if.sv
// handshake channels of the key matrix row debouncer
interface kmrd_in_if;
  logic              valid;
  logic              ready;
  kmrd_pkg::now_t    now_ms;
  kmrd_pkg::col_t    col_bits;
  modport source (output valid, output now_ms, output col_bits, input ready);
  modport sink   (input valid, input now_ms, input col_bits, output ready);
endinterface

interface kmrd_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [kmrd_pkg::ROW_OUT_W-1:0]           row_index;
  logic                                     sampled;
  kmrd_pkg::col_t                           row_keys;
  logic                                     bounce_seen;
  logic [kmrd_pkg::TOTAL_OUT_W-1:0]         pressed_total;
  modport source (output valid, output row_index, output sampled, output row_keys,
                  output bounce_seen, output pressed_total, input ready);
  modport sink   (input valid, input row_index, input sampled, input row_keys,
                  input bounce_seen, input pressed_total, output ready);
endinterface

interface kmrd_cfg_if;
  logic           valid;
  logic           ready;
  kmrd_pkg::len_t debounce_len;
  modport source (output valid, output debounce_len, input ready);
  modport sink   (input valid, input debounce_len, output ready);
endinterface

### rtl/core/key_matrix_row_debouncer.sv
// key matrix row scanner with shift-register debounce, histories kept in a row-wide ram
//
// Each input beat carries the timer value and the column samples of the row now
// selected; the block handles rows in turn and returns one result beat per input
// beat. It takes one beat per clock cycle while the output is not stalled; on accept
// the synchronous history ram read is issued and the beat enters stage 1, and when
// stage 1 advances, the shift, classify and write-back result is loaded into the
// output register.
// Histories of a whole row live in one ram word; a row written in the cycle its
// next read is issued is forwarded. Per-row valid bits stand in for the cleared
// ram after reset, so no clearing pass is needed. The debounce length register
// may be written at any time the block is idle and is always ready.
module key_matrix_row_debouncer (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmrd_in_if.sink   in_i,
  kmrd_cfg_if.sink  cfg_i,
  kmrd_out_if.source out_o
);
  import kmrd_pkg::*;

  len_t      len_q;
  row_t      scan_row_q;
  now_t      stamp_q;
  now_t      latched_q;
  scan_t     s1_q;
  logic      s1_valid_q;
  hist_row_t hist_mem [ROWS];
  hist_row_t hist_rd_q;
  logic      rd_vld_q;
  logic [ROWS-1:0] hist_vld_q;
  logic      fwd_hit_q;
  hist_row_t fwd_q;
  keys_t     key_state_q [ROWS];
  total_t    total_q;
  logic      out_valid_q;

  logic      in_acc;
  logic      s1_adv;
  logic      row_zero;
  now_t      elapsed;
  logic      sampled;
  logic [SHIFT_W-1:0] shift;
  scan_t     s1_d;
  row_t      row_next;
  hist_row_t hist_cur;
  hist_row_t hist_new;
  keys_t     keys_old;
  keys_t     keys_new;
  logic      bounce;
  hist_t     mask;
  len_t      len_eff;
  total_t    total_d;
  col_t      row_keys_out;

  assign cfg_i.ready = 1'b1;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_i.ready;

  // elapsed time is measured at row 0 and reused by the other rows
  always_comb begin
    row_zero = (scan_row_q == '0);
    elapsed  = row_zero ? (in_i.now_ms - stamp_q) : latched_q;
    sampled  = (elapsed != '0);
    if (elapsed[7:0] == 8'd0 || elapsed[7:3] != 5'd0) begin
      shift = SHIFT_FULL;
    end else begin
      shift = SHIFT_W'(elapsed[2:0]);
    end
    row_next = (scan_row_q == row_t'(ROWS - 1)) ? '0 : scan_row_q + row_t'(1);
    s1_d.row     = scan_row_q;
    s1_d.sampled = sampled;
    s1_d.shift   = shift;
    s1_d.cols    = in_i.col_bits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LEN_RST;
      scan_row_q <= '0;
      stamp_q    <= '0;
      latched_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        len_q <= cfg_i.debounce_len;
      end
      if (in_acc) begin
        scan_row_q <= row_next;
        if (row_zero) begin
          latched_q <= elapsed;
          if (sampled) begin
            stamp_q <= in_i.now_ms;
          end
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // history ram: read at accept, written back when a sampled item leaves stage 1
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_rd_q <= hist_mem[scan_row_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.sampled) begin
      hist_mem[s1_q.row] <= hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (s1_adv && s1_q.sampled) begin
        hist_vld_q[s1_q.row] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q  <= hist_vld_q[scan_row_q];
        fwd_hit_q <= s1_adv && s1_q.sampled && (s1_q.row == scan_row_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_q <= hist_new;
    end
  end

  // shift in the sample and classify each column
  always_comb begin
    hist_t h;
    hist_t hs;
    hist_t fill;
    hist_t v;
    hist_t w;
    logic  bit_in;
    logic [HIST_W:0] v1;
    logic [HIST_W:0] w1;

    if (fwd_hit_q) begin
      hist_cur = fwd_q;
    end else if (rd_vld_q) begin
      hist_cur = hist_rd_q;
    end else begin
      hist_cur = '0;
    end

    if (len_q < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (len_q > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_q;
    end
    mask = HIST_W'(((HIST_W + 1)'(1) << len_eff) - (HIST_W + 1)'(1));

    keys_old = key_state_q[s1_q.row];
    keys_new = keys_old;
    bounce   = 1'b0;
    hist_new = hist_cur;

    for (int c = 0; c < COLS; c++) begin
      h      = hist_cur[c*HIST_W +: HIST_W];
      bit_in = (c < COL_W) ? s1_q.cols[c] : 1'b0;
      fill   = bit_in ? HIST_W'((hist_t'(1) << s1_q.shift) - hist_t'(1)) : '0;
      if (s1_q.shift >= SHIFT_FULL) begin
        hs = {HIST_W{bit_in}};
      end else begin
        hs = (h << s1_q.shift) | fill;
      end
      hist_new[c*HIST_W +: HIST_W] = hs;
      v  = hs & mask;
      w  = ~v & mask;
      v1 = {1'b0, v} + (HIST_W + 1)'(1);
      w1 = {1'b0, w} + (HIST_W + 1)'(1);
      if (v == '0) begin
        keys_new[c] = 1'b0;
      end else if ((v1 & {1'b0, v}) == '0) begin
        keys_new[c] = 1'b1;
      end else if ((w1 & {1'b0, w}) == '0) begin
        keys_new[c] = keys_old[c];
      end else begin
        bounce = 1'b1;
      end
    end

    if (!s1_q.sampled) begin
      keys_new = keys_old;
      bounce   = 1'b0;
    end

    // running count: drop the row's old keys, add its new ones
    total_d = total_q - total_t'(pop_keys(keys_old)) + total_t'(pop_keys(keys_new));

    for (int c = 0; c < COL_W; c++) begin
      row_keys_out[c] = (c < COLS) ? keys_new[c] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        key_state_q[r] <= '0;
      end
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        key_state_q[s1_q.row] <= keys_new;
        total_q               <= total_d;
        out_valid_q           <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_o.row_index   <= ROW_OUT_W'(s1_q.row);
      out_o.sampled     <= s1_q.sampled;
      out_o.row_keys    <= row_keys_out;
      out_o.bounce_seen <= bounce;
      if (int'(total_d) > TOTAL_SAT) begin
        out_o.pressed_total <= TOTAL_OUT_W'(TOTAL_SAT);
      end else begin
        out_o.pressed_total <= TOTAL_OUT_W'(total_d);
      end
    end
  end

  assign out_o.valid = out_valid_q;

  a_fwd_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarded history without an item in stage 1");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat did not reach stage 1");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(total_q) <= ROWS * COLS)
    else $error("pressed key count beyond matrix size");

  a_row_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(scan_row_q) < ROWS)
    else $error("scan row out of range");

  a_write_marks_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.sampled) |=> hist_vld_q[$past(s1_q.row)])
    else $error("written history row not marked valid");

endmodule
